[rtl/scc_pkg.sv]
// Shared constants and control/status types for the strongly connected
// components block. No dependencies.
package scc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 1024;
    localparam int VW = $clog2(MAX_VERTICES);      // vertex width
    localparam int CW = VW + 1;                    // vertex count width
    localparam int EA = $clog2(MAX_EDGES);         // edge store address width
    localparam int EW = EA + 1;                    // edge total width
    localparam int SW = VW + EW;                   // stack frame width

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // accept an input request
        logic clr;         // clear marks and counters
        logic inc_i;       // skip a visited root
        logic start_root;  // begin a pass one search at root i
        logic finish;      // append current vertex to finish order
        logic pop_read;    // read the frame below the top
        logic rd_edge;     // read edge at cur_pos-1
        logic push1;       // descend to the sink of the edge just read
        logic load_top;    // load the popped frame into the top registers
        logic fin_read;    // pop the finish order
        logic start_comp;  // open a new component at the popped vertex
        logic scan_init;   // restart the in-edge scan
        logic rd_scan;     // read the next edge of the scan
        logic scan_chk;    // compare the scanned edge against the best
        logic p2_push;     // descend to the best source
        logic comp_end;    // close the component
        logic flush;       // send the last result, clear the graph
    } t_cmd;

    typedef struct packed {
        logic root_end;
        logic root_vis;
        logic pos_zero;
        logic depth_one;
        logic edge_hit;
        logic fin_empty;
        logic v_assigned;
        logic pend_block;
        logic out_free;
        logic scan_end;
        logic best_ok;
    } t_sts;

endpackage

[rtl/scc_ctrl.sv]
// Sequencer for both passes of the component search.
// Depends on scc_pkg.
module scc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_edge,
    input  scc_pkg::t_sts i_sts,
    output scc_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import scc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_ROOT   = 4'd2;
    localparam logic [3:0] S_P1CHK  = 4'd3;
    localparam logic [3:0] S_P1EDGE = 4'd4;
    localparam logic [3:0] S_P1POPW = 4'd5;
    localparam logic [3:0] S_P2POP  = 4'd6;
    localparam logic [3:0] S_P2V    = 4'd7;
    localparam logic [3:0] S_SCAN0  = 4'd8;
    localparam logic [3:0] S_SCANR  = 4'd9;
    localparam logic [3:0] S_SCANC  = 4'd10;
    localparam logic [3:0] S_DECIDE = 4'd11;
    localparam logic [3:0] S_P2POPW = 4'd12;
    localparam logic [3:0] S_FLUSH  = 4'd13;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_edge) n_state = S_CLR;
                end
            end
            S_CLR: begin
                o_cmd.clr = 1'b1;
                n_state   = S_ROOT;
            end
            S_ROOT: begin
                if (i_sts.root_end) begin
                    n_state = S_P2POP;
                end else if (i_sts.root_vis) begin
                    o_cmd.inc_i = 1'b1;
                end else begin
                    o_cmd.start_root = 1'b1;
                    n_state = S_P1CHK;
                end
            end
            S_P1CHK: begin
                if (i_sts.pos_zero) begin
                    o_cmd.finish = 1'b1;
                    if (i_sts.depth_one) begin
                        n_state = S_ROOT;
                    end else begin
                        o_cmd.pop_read = 1'b1;
                        n_state = S_P1POPW;
                    end
                end else begin
                    o_cmd.rd_edge = 1'b1;
                    n_state = S_P1EDGE;
                end
            end
            S_P1EDGE: begin
                o_cmd.push1 = i_sts.edge_hit;
                n_state = S_P1CHK;
            end
            S_P1POPW: begin
                o_cmd.load_top = 1'b1;
                n_state = S_P1CHK;
            end
            S_P2POP: begin
                if (i_sts.fin_empty) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.fin_read = 1'b1;
                    n_state = S_P2V;
                end
            end
            S_P2V: begin
                if (i_sts.v_assigned) begin
                    n_state = S_P2POP;
                end else if (!i_sts.pend_block) begin
                    o_cmd.start_comp = 1'b1;
                    n_state = S_SCAN0;
                end
            end
            S_SCAN0: begin
                o_cmd.scan_init = 1'b1;
                n_state = S_SCANR;
            end
            S_SCANR: begin
                if (i_sts.scan_end) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state = S_SCANC;
                end
            end
            S_SCANC: begin
                o_cmd.scan_chk = 1'b1;
                n_state = S_SCANR;
            end
            S_DECIDE: begin
                if (i_sts.best_ok) begin
                    if (!i_sts.pend_block) begin
                        o_cmd.p2_push = 1'b1;
                        n_state = S_SCAN0;
                    end
                end else if (i_sts.depth_one) begin
                    o_cmd.comp_end = 1'b1;
                    n_state = S_P2POP;
                end else begin
                    o_cmd.pop_read = 1'b1;
                    n_state = S_P2POPW;
                end
            end
            S_P2POPW: begin
                o_cmd.load_top = 1'b1;
                n_state = S_SCAN0;
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/scc_dp.sv]
// Datapath: edge store, search stack, finish order, marks and result registers.
// Depends on scc_pkg.
module scc_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  scc_pkg::t_cmd         i_cmd,
    output scc_pkg::t_sts         o_sts,
    input  logic                  i_cfg_we,
    input  logic [scc_pkg::CW-1:0] i_cfg_data,
    input  logic [scc_pkg::VW-1:0] i_edge_source,
    input  logic [scc_pkg::VW-1:0] i_edge_sink,
    input  logic                  i_edge_present,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [scc_pkg::VW-1:0] o_component_number,
    output logic [scc_pkg::VW-1:0] o_member_vertex,
    output logic                  o_component_end,
    output logic                  o_run_end,
    output logic                  o_edges_dropped
);
    import scc_pkg::*;

    localparam logic [CW-1:0] NMAX = CW'(MAX_VERTICES);
    localparam logic [EW-1:0] EMAX = EW'(MAX_EDGES);

    // memories
    logic [2*VW-1:0] r_edge_mem [MAX_EDGES];
    logic [SW-1:0]   r_stk_mem  [MAX_VERTICES];
    logic [VW-1:0]   r_fin_mem  [MAX_VERTICES];
    logic [2*VW-1:0] r_edge_rd;
    logic [SW-1:0]   r_stk_rd;
    logic [VW-1:0]   r_fin_rd;

    logic [CW-1:0]          r_vcount;
    logic [EW-1:0]          r_total;
    logic                   r_drop;
    logic [MAX_VERTICES-1:0] r_visited, r_assigned;
    logic [CW-1:0]          r_i, r_depth, r_fin_cnt;
    logic [VW-1:0]          r_cur_v;
    logic [EW-1:0]          r_cur_pos;
    logic [EW-1:0]          r_scan;
    logic [VW-1:0]          r_best;
    logic                   r_best_ok;
    logic [VW-1:0]          r_comp;
    logic                   r_pend_valid;
    logic [VW-1:0]          r_pend_comp, r_pend_v;
    logic                   r_pend_cend;

    logic [CW-1:0] n_eff;
    logic [VW-1:0] e_src, e_snk;
    logic          edge_ok, out_free, emit_new, pend_push, scan_better;
    logic [EA-1:0] rd_addr;
    logic [CW-1:0] depth_m1, depth_m2, fin_m1;

    always_comb begin
        if (r_vcount == '0)      n_eff = CW'(1);
        else if (r_vcount > NMAX) n_eff = NMAX;
        else                     n_eff = r_vcount;
    end

    assign e_src    = r_edge_rd[2*VW-1:VW];
    assign e_snk    = r_edge_rd[VW-1:0];
    assign edge_ok  = ({1'b0, i_edge_source} < n_eff) && ({1'b0, i_edge_sink} < n_eff)
                      && (r_total < EMAX);
    assign out_free = !o_out_valid || !i_out_stall;
    assign emit_new = i_cmd.start_comp || i_cmd.p2_push;
    assign pend_push = (emit_new && r_pend_valid) || i_cmd.flush;
    assign depth_m1 = r_depth - CW'(1);
    assign depth_m2 = r_depth - CW'(2);
    assign fin_m1   = r_fin_cnt - CW'(1);
    assign rd_addr  = i_cmd.rd_edge ? EA'(r_cur_pos - EW'(1)) : r_scan[EA-1:0];
    assign scan_better = (e_snk == r_cur_v) && ({1'b0, e_src} < n_eff)
                         && !r_assigned[e_src] && (!r_best_ok || e_src > r_best);

    always_comb begin
        o_sts.root_end   = (r_i == n_eff);
        o_sts.root_vis   = r_visited[r_i[VW-1:0]];
        o_sts.pos_zero   = (r_cur_pos == '0);
        o_sts.depth_one  = (r_depth == CW'(1));
        o_sts.edge_hit   = (e_src == r_cur_v) && ({1'b0, e_snk} < n_eff)
                           && !r_visited[e_snk];
        o_sts.fin_empty  = (r_fin_cnt == '0);
        o_sts.v_assigned = r_assigned[r_fin_rd];
        o_sts.pend_block = r_pend_valid && !out_free;
        o_sts.out_free   = out_free;
        o_sts.scan_end   = (r_scan == r_total);
        o_sts.best_ok    = r_best_ok;
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_edge_present && edge_ok) begin
            r_edge_mem[r_total[EA-1:0]] <= {i_edge_source, i_edge_sink};
        end
        if (i_cmd.rd_edge || i_cmd.rd_scan) begin
            r_edge_rd <= r_edge_mem[rd_addr];
        end
        if (i_cmd.push1 || i_cmd.p2_push) begin
            r_stk_mem[depth_m1[VW-1:0]] <= {r_cur_v, r_cur_pos};
        end
        if (i_cmd.pop_read) begin
            r_stk_rd <= r_stk_mem[depth_m2[VW-1:0]];
        end
        if (i_cmd.finish) begin
            r_fin_mem[r_fin_cnt[VW-1:0]] <= r_cur_v;
        end
        if (i_cmd.fin_read) begin
            r_fin_rd <= r_fin_mem[fin_m1[VW-1:0]];
        end
    end

    // search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount     <= CW'(1);
            r_total      <= '0;
            r_drop       <= 1'b0;
            r_visited    <= '0;
            r_assigned   <= '0;
            r_i          <= '0;
            r_depth      <= '0;
            r_fin_cnt    <= '0;
            r_comp       <= '0;
            r_best_ok    <= 1'b0;
            r_pend_valid <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_vcount <= i_cfg_data;
            if (i_cmd.load && i_edge_present) begin
                if (edge_ok) r_total <= r_total + EW'(1);
                else         r_drop  <= 1'b1;
            end
            if (i_cmd.clr) begin
                r_visited  <= '0;
                r_assigned <= '0;
                r_i        <= '0;
                r_fin_cnt  <= '0;
                r_comp     <= '0;
            end
            if (i_cmd.inc_i) r_i <= r_i + CW'(1);
            if (i_cmd.start_root) begin
                r_i <= r_i + CW'(1);
                r_visited[r_i[VW-1:0]] <= 1'b1;
                r_cur_v   <= r_i[VW-1:0];
                r_cur_pos <= r_total;
                r_depth   <= CW'(1);
            end
            if (i_cmd.finish) begin
                r_fin_cnt <= r_fin_cnt + CW'(1);
                if (r_depth == CW'(1)) r_depth <= '0;
            end
            if (i_cmd.pop_read) r_depth <= depth_m1;
            if (i_cmd.rd_edge) r_cur_pos <= r_cur_pos - EW'(1);
            if (i_cmd.push1) begin
                r_visited[e_snk] <= 1'b1;
                r_cur_v   <= e_snk;
                r_cur_pos <= r_total;
                r_depth   <= r_depth + CW'(1);
            end
            if (i_cmd.load_top) begin
                r_cur_v   <= r_stk_rd[SW-1:EW];
                r_cur_pos <= r_stk_rd[EW-1:0];
            end
            if (i_cmd.fin_read) r_fin_cnt <= fin_m1;
            if (i_cmd.start_comp) begin
                r_assigned[r_fin_rd] <= 1'b1;
                r_cur_v <= r_fin_rd;
                r_depth <= CW'(1);
            end
            if (i_cmd.scan_init) begin
                r_scan    <= '0;
                r_best_ok <= 1'b0;
            end
            if (i_cmd.rd_scan) r_scan <= r_scan + EW'(1);
            if (i_cmd.scan_chk && scan_better) begin
                r_best    <= e_src;
                r_best_ok <= 1'b1;
            end
            if (i_cmd.p2_push) begin
                r_assigned[r_best] <= 1'b1;
                r_cur_v <= r_best;
                r_depth <= r_depth + CW'(1);
            end
            if (i_cmd.comp_end) begin
                r_pend_cend <= 1'b1;
                r_comp      <= r_comp + VW'(1);
            end
            // pending result holds back one vertex so its end flags can be set
            if (emit_new) begin
                r_pend_valid <= 1'b1;
                r_pend_comp  <= r_comp;
                r_pend_v     <= i_cmd.start_comp ? r_fin_rd : r_best;
                r_pend_cend  <= 1'b0;
            end
            if (pend_push) begin
                o_out_valid        <= 1'b1;
                o_component_number <= r_pend_comp;
                o_member_vertex    <= r_pend_v;
                o_component_end    <= r_pend_cend;
                o_run_end          <= i_cmd.flush;
                o_edges_dropped    <= r_drop;
            end else if (out_free) begin
                o_out_valid <= 1'b0;
            end
            if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
                r_total      <= '0;
                r_drop       <= 1'b0;
            end
        end
    end

endmodule

[rtl/strongly_connected_components.sv]
// Top level of the strongly connected components block.
// Joins scc_ctrl and scc_dp; depends on scc_pkg.
//
// Usage: each input request carries one directed edge (edge_present) and may
// mark the end of the graph (last_edge). Edges load one per cycle while the
// block is idle; bad endpoints or a full 1024-entry store drop the edge and
// set edges_dropped for the coming answer.
// On the request marked last_edge the input stalls and the two-pass search
// runs. Pass one walks the edge store newest-first from each root; every
// vertex reads all E entries through the single edge store read port.
// Pass two finds each vertex's highest unassigned in-neighbor by a full
// sweep of the store, about two sweeps per vertex.
// One result request per vertex follows, grouped by component; component_end
// marks a component's last vertex and run_end the answer's last result.
// Results leave through an output register; a stall from the receiver holds
// it and pauses the search only when a new result is ready to replace it.
// Reset (synchronous, active low) clears the edge count, drop flag, control
// state and sets vertex_count to 1; memories need no clearing.
// vertex_count may be written only while the block is idle.
module strongly_connected_components (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [scc_pkg::CW-1:0] i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [scc_pkg::VW-1:0] i_edge_source,
    input  logic [scc_pkg::VW-1:0] i_edge_sink,
    input  logic                   i_edge_present,
    input  logic                   i_last_edge,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [scc_pkg::VW-1:0] o_component_number,
    output logic [scc_pkg::VW-1:0] o_member_vertex,
    output logic                   o_component_end,
    output logic                   o_run_end,
    output logic                   o_edges_dropped
);
    import scc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: accepts requests in idle, then steps through both passes
    scc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_edge (i_last_edge),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    // storage, marks and result registers
    scc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_edge_source      (i_edge_source),
        .i_edge_sink        (i_edge_sink),
        .i_edge_present     (i_edge_present),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_component_number (o_component_number),
        .o_member_vertex    (o_member_vertex),
        .o_component_end    (o_component_end),
        .o_run_end          (o_run_end),
        .o_edges_dropped    (o_edges_dropped)
    );

endmodule
